// ----- hdl/two_button_short_long_press_macros.svh -----
// Assertion macros for the two-button short/long press qualifier.
`ifndef TWO_BUTTON_SHORT_LONG_PRESS_MACROS_SVH
`define TWO_BUTTON_SHORT_LONG_PRESS_MACROS_SVH

`ifndef SYNTH

// Consequence must hold in the same cycle as the antecedent.
`define TBSLP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define TBSLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TBSLP_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define TBSLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- hdl/tbslp_pkg.sv -----
// Types and constants shared by the two-button short/long press qualifier.
`timescale 1ns / 1ps
`default_nettype none

package tbslp_pkg;

  localparam int SampleW = 5;
  localparam int BeepEndW = 7;
  localparam int LongW = 8;
  localparam int RearmW = 8;
  localparam int CountW = 8;
  localparam int CfgDataW = 8;
  localparam int CfgIndexW = 3;
  localparam int CodeW = 3;

  localparam logic [SampleW-1:0] SAMPLE_TICK_RESET = 5'd10;
  localparam logic [BeepEndW-1:0] BEEP_END_TICK_RESET = 7'd28;
  localparam logic [LongW-1:0] LONG_PRESS_TICK_RESET = 8'd124;
  localparam logic [RearmW-1:0] REARM_TICK_RESET = 8'd210;

  localparam logic [CountW-1:0] JUMP_AFTER_SAMPLE = 8'd24;
  localparam logic [CountW-1:0] JUMP_AFTER_REPORT = 8'd200;
  localparam logic [CountW-1:0] COUNT_MAX = 8'd255;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_EDGE = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [CfgIndexW-1:0] CFG_SAMPLE_TICK = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_BEEP_END_TICK = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_LONG_PRESS_TICK = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_REARM_TICK = 3'd3;

  localparam logic [CodeW-1:0] CODE_NONE = 3'd0;
  localparam logic [CodeW-1:0] CODE_TOP_SHORT = 3'd1;
  localparam logic [CodeW-1:0] CODE_BOTTOM_SHORT = 3'd2;
  localparam logic [CodeW-1:0] CODE_TOP_LONG = 3'd3;
  localparam logic [CodeW-1:0] CODE_BOTTOM_LONG = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic       top_level;
    logic       bottom_level;
  } item_t;

  typedef struct packed {
    logic             buzzer;
    logic [CodeW-1:0] press_code;
    logic             busy_res;
  } result_t;

  typedef struct packed {
    logic [SampleW-1:0]  sample_tick;
    logic [BeepEndW-1:0] beep_end_tick;
    logic [LongW-1:0]    long_press_tick;
    logic [RearmW-1:0]   rearm_tick;
  } cfg_t;

  typedef struct packed {
    logic              running;
    logic [CountW-1:0] phase_count;
  } status_t;

endpackage

`default_nettype wire

// ----- hdl/tbslp_cfg_regs.sv -----
// Configuration registers for the two-button short/long press qualifier.
`timescale 1ns / 1ps
`default_nettype none

module tbslp_cfg_regs
  import tbslp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_tick <= SAMPLE_TICK_RESET;
      cfg.beep_end_tick <= BEEP_END_TICK_RESET;
      cfg.long_press_tick <= LONG_PRESS_TICK_RESET;
      cfg.rearm_tick <= REARM_TICK_RESET;
    end else if (cfg_we) begin
      // Values are cut to the register width; unknown indexes are dropped.
      case (cfg_index)
        CFG_SAMPLE_TICK: cfg.sample_tick <= cfg_data[SampleW-1:0];
        CFG_BEEP_END_TICK: cfg.beep_end_tick <= cfg_data[BeepEndW-1:0];
        CFG_LONG_PRESS_TICK: cfg.long_press_tick <= cfg_data[LongW-1:0];
        CFG_REARM_TICK: cfg.rearm_tick <= cfg_data[RearmW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tbslp_in_reg.sv -----
// Input register stage holding one request for the core.
`timescale 1ns / 1ps
`default_nettype none

module tbslp_in_reg
  import tbslp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  output logic      item_stall,
  input  item_t     item,
  input  wire logic take,
  output logic      held_valid,
  output item_t     held
);

  logic load;

  // The stage refills in the same cycle that its request moves on.
  assign item_stall = held_valid && !take;
  assign load = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/tbslp_core.sv -----
// Press sequencer state and its single-pass update for each request.
`timescale 1ns / 1ps
`default_nettype none

module tbslp_core
  import tbslp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  cfg_t      cfg,
  input  wire logic fire,
  input  item_t     held,
  output result_t   result_next,
  output status_t   status
);

  logic [CountW-1:0] phase_count;
  logic              running;
  logic              latched_bottom;
  logic [CodeW-1:0]  pending_code;
  logic              buzzer_state;

  logic [CountW-1:0] phase_count_next;
  logic              running_next;
  logic              latched_bottom_next;
  logic [CodeW-1:0]  pending_code_next;
  logic              buzzer_state_next;
  logic [CodeW-1:0]  code;

  logic [CountW-1:0] c_mid;
  logic              idle_now;
  logic              released;
  logic              hit_sample;
  logic              in_beep;
  logic              hit_long;
  logic              in_rearm;

  assign released = !held.top_level && !held.bottom_level;
  assign hit_sample = phase_count == {{(CountW-SampleW){1'b0}}, cfg.sample_tick};
  assign in_beep = (phase_count >= {{(CountW-BeepEndW){1'b0}}, cfg.beep_end_tick})
                && (phase_count < cfg.long_press_tick);
  assign hit_long = phase_count == cfg.long_press_tick;
  assign in_rearm = phase_count >= cfg.rearm_tick;

  always_comb begin
    phase_count_next = phase_count;
    running_next = running;
    latched_bottom_next = latched_bottom;
    pending_code_next = pending_code;
    buzzer_state_next = buzzer_state;
    code = CODE_NONE;
    c_mid = phase_count;
    idle_now = 1'b0;

    case (held.func)
      FUNC_TICK: begin
        if (running) begin
          if (hit_sample) begin
            if (held.top_level) begin
              latched_bottom_next = 1'b0;
              c_mid = JUMP_AFTER_SAMPLE;
              buzzer_state_next = 1'b1;
            end else if (held.bottom_level) begin
              latched_bottom_next = 1'b1;
              c_mid = JUMP_AFTER_SAMPLE;
              buzzer_state_next = 1'b1;
            end else begin
              idle_now = 1'b1;
            end
          end else if (in_beep) begin
            buzzer_state_next = 1'b0;
            if (released) begin
              pending_code_next = latched_bottom ? CODE_BOTTOM_SHORT : CODE_TOP_SHORT;
              c_mid = JUMP_AFTER_REPORT;
            end
          end else if (hit_long) begin
            pending_code_next = latched_bottom ? CODE_BOTTOM_LONG : CODE_TOP_LONG;
            c_mid = JUMP_AFTER_REPORT;
          end else if (in_rearm && released) begin
            idle_now = 1'b1;
          end

          if (idle_now) begin
            running_next = 1'b0;
            phase_count_next = '0;
          end else if (c_mid != COUNT_MAX) begin
            phase_count_next = c_mid + 1'b1;
          end else begin
            phase_count_next = c_mid;
          end
        end
      end
      FUNC_EDGE: begin
        if (!running) begin
          running_next = 1'b1;
          phase_count_next = '0;
        end
      end
      FUNC_READ: begin
        code = pending_code;
        pending_code_next = CODE_NONE;
      end
      default: ;
    endcase

    result_next.buzzer = buzzer_state_next;
    result_next.press_code = code;
    result_next.busy_res = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      running <= 1'b0;
      latched_bottom <= 1'b0;
      pending_code <= CODE_NONE;
      buzzer_state <= 1'b0;
    end else if (fire) begin
      phase_count <= phase_count_next;
      running <= running_next;
      latched_bottom <= latched_bottom_next;
      pending_code <= pending_code_next;
      buzzer_state <= buzzer_state_next;
    end
  end

  assign status.running = running;
  assign status.phase_count = phase_count;

endmodule

`default_nettype wire

// ----- hdl/tbslp_out_reg.sv -----
// Result register that holds one result until downstream takes it.
`timescale 1ns / 1ps
`default_nettype none

module tbslp_out_reg
  import tbslp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic load,
  input  result_t   result_next,
  output logic      ready,
  output logic      result_valid,
  input  wire logic result_stall,
  output result_t   result
);

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/two_button_short_long_press.sv -----
// Top level of the two-button short/long press qualifier.
//
//   Channel  Direction  Handshake                Payload
//   item     in         item_valid / item_stall  item_t: func, top_level, bottom_level
//   result   out        result_valid / result_stall  result_t: buzzer, press_code, busy_res
//   cfg      in         cfg_we                   cfg_index, cfg_data
//
// One request per clock cycle is accepted while the result channel does not stall; its
// result passes through the input register and the result register around the state update.
// Each accepted request gives exactly one result.
// Reset clears the press state and loads the register defaults; no clearing pass.
// A stalled result holds the result register, which then stalls the input register.
`timescale 1ns / 1ps
`default_nettype none

`include "two_button_short_long_press_macros.svh"

module two_button_short_long_press
  import tbslp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  item_t                     item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   held;
  logic    held_valid;
  logic    ready;
  logic    fire;
  result_t result_next;
  status_t status;

  assign fire = held_valid && ready;

  tbslp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tbslp_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .take       (ready),
    .held_valid (held_valid),
    .held       (held)
  );

  tbslp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .fire        (fire),
    .held        (held),
    .result_next (result_next),
    .status      (status)
  );

  tbslp_out_reg u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (fire),
    .result_next  (result_next),
    .ready        (ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  `TBSLP_ASSERT_NOW(a_idle_count_zero, clk, rst, !status.running, status.phase_count == '0, "phase count not zero while idle")
  `TBSLP_ASSERT_NOW(a_code_range, clk, rst, result_valid, result.press_code <= CODE_BOTTOM_LONG, "press code out of range")
  `TBSLP_ASSERT_NOW(a_stall_full, clk, rst, item_stall, held_valid && result_valid && result_stall, "input stalled without a full pipeline")
  `TBSLP_ASSERT_NEXT(a_fire_gives_result, clk, rst, fire, result_valid, "accepted request gave no result")

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the two-button short/long press qualifier.
`timescale 1ns / 1ps

module testbench;
  import tbslp_pkg::*;

  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_PRINTED = 40;
  localparam int SETTLE_TICKS = 300;

  logic                 clk;
  logic                 rst;
  logic                 item_valid;
  logic                 item_stall;
  item_t                request;
  logic                 result_valid;
  logic                 result_stall;
  result_t              outcome;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  // Own copy of the qualifier state and its timing registers.
  cfg_t              q_cfg;
  logic [CountW-1:0] q_count;
  logic              q_running;
  logic              q_latched_bottom;
  logic [CodeW-1:0]  q_pending;
  logic              q_buzzer;

  result_t due_results[$];
  int      mismatch_count;
  int      items_sent;
  int      cycle_count;
  int      sender_idle_pct;
  int      receiver_stall_pct;

  two_button_short_long_press i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (request),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (outcome),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic result_t qualify_press(input item_t req);
    result_t           res;
    logic [CountW-1:0] c;
    logic              released;
    logic              to_idle;
    res = '0;
    case (req.func)
      FUNC_TICK: begin
        if (q_running) begin
          c = q_count;
          released = !req.top_level && !req.bottom_level;
          to_idle = 1'b0;
          // The sample test wins over the windows, which are tried in a fixed order.
          if (c == q_cfg.sample_tick) begin
            if (req.top_level) begin
              q_latched_bottom = 1'b0;
              c = JUMP_AFTER_SAMPLE;
              q_buzzer = 1'b1;
            end else if (req.bottom_level) begin
              q_latched_bottom = 1'b1;
              c = JUMP_AFTER_SAMPLE;
              q_buzzer = 1'b1;
            end else begin
              to_idle = 1'b1;
            end
          end else if (c >= q_cfg.beep_end_tick && c < q_cfg.long_press_tick) begin
            q_buzzer = 1'b0;
            if (released) begin
              q_pending = q_latched_bottom ? CODE_BOTTOM_SHORT : CODE_TOP_SHORT;
              c = JUMP_AFTER_REPORT;
            end
          end else if (c == q_cfg.long_press_tick) begin
            q_pending = q_latched_bottom ? CODE_BOTTOM_LONG : CODE_TOP_LONG;
            c = JUMP_AFTER_REPORT;
          end else if (c >= q_cfg.rearm_tick && released) begin
            to_idle = 1'b1;
          end
          if (to_idle) begin
            q_running = 1'b0;
            q_count = '0;
          end else begin
            if (c != COUNT_MAX) c = c + 1'b1;
            q_count = c;
          end
        end
      end
      FUNC_EDGE: begin
        if (!q_running) begin
          q_running = 1'b1;
          q_count = '0;
        end
      end
      FUNC_READ: begin
        res.press_code = q_pending;
        q_pending = CODE_NONE;
      end
      default: ;
    endcase
    res.buzzer = q_buzzer;
    res.busy_res = q_running;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  task automatic send(input logic [1:0] func, input logic top, input logic bottom);
    item_t req;
    req.func = func;
    req.top_level = top;
    req.bottom_level = bottom;
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    request <= req;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    due_results.push_back(qualify_press(req));
    items_sent++;
  endtask

  task automatic drain_pipeline();
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIndexW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_SAMPLE_TICK:     q_cfg.sample_tick = data[SampleW-1:0];
      CFG_BEEP_END_TICK:   q_cfg.beep_end_tick = data[BeepEndW-1:0];
      CFG_LONG_PRESS_TICK: q_cfg.long_press_tick = data[LongW-1:0];
      CFG_REARM_TICK:      q_cfg.rearm_tick = data[RearmW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Writes all four timing registers, then one random index past the last, which must be ignored.
  task automatic configure(input logic [CfgDataW-1:0] sample, input logic [CfgDataW-1:0] beep_end,
                           input logic [CfgDataW-1:0] long_press,
                           input logic [CfgDataW-1:0] rearm);
    drain_pipeline();
    write_register(CFG_SAMPLE_TICK, sample);
    write_register(CFG_BEEP_END_TICK, beep_end);
    write_register(CFG_LONG_PRESS_TICK, long_press);
    write_register(CFG_REARM_TICK, rearm);
    write_register(CfgIndexW'($urandom_range(int'(CFG_REARM_TICK) + 1, (1 << CfgIndexW) - 1)),
                   CfgDataW'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Occasional reads and edges in the middle of a press; an edge is ignored while a press runs.
  task automatic side_traffic();
    if ($urandom_range(15) == 0) begin
      send(FUNC_READ, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end else if ($urandom_range(31) == 0) begin
      send(FUNC_EDGE, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  task automatic press_sequence();
    int   button;
    int   hold;
    int   n;
    int   sample_at;
    int   long_at;
    logic top;
    logic bottom;
    button = $urandom_range(9);
    sample_at = int'(q_cfg.sample_tick) + 1;
    long_at = sample_at + int'(q_cfg.long_press_tick) - int'(JUMP_AFTER_SAMPLE);
    if (long_at < sample_at) long_at = sample_at + 4;
    if ($urandom_range(2) != 0) hold = $urandom_range(0, long_at);
    else hold = $urandom_range(long_at, long_at + 70);
    send(FUNC_EDGE, 1'($urandom_range(1)), 1'($urandom_range(1)));
    for (n = 1; n <= hold; n++) begin
      // Contact bounce before the sample point does not matter to the result.
      if (n < sample_at && $urandom_range(3) == 0) begin
        {top, bottom} = 2'($urandom_range(3));
      end else begin
        top = (button == 1) || (button >= 2 && button <= 5);
        bottom = (button == 1) || (button >= 6);
      end
      send(FUNC_TICK, top, bottom);
      side_traffic();
    end
    n = 0;
    while (q_running && n < SETTLE_TICKS) begin
      n++;
      send(FUNC_TICK, 1'b0, 1'b0);
      side_traffic();
    end
    send(FUNC_READ, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // A phase stops at the first press sequence or burst of random requests that ends past its budget.
  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int budget);
    int start;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send(2'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        end
      end else begin
        press_sequence();
      end
    end
    drain_pipeline();
  endtask

  task automatic test_quiet_items();
    send(FUNC_TICK, 1'b1, 1'b1);
    send(FUNC_SPARE, 1'b1, 1'b1);
    send(FUNC_READ, 1'b0, 1'b0);
    send(FUNC_SPARE, 1'b0, 1'b0);
    drain_pipeline();
  endtask

  // Both buttons held at the sample point: the top one wins.
  task automatic test_short_press();
    send(FUNC_EDGE, 1'b0, 1'b0);
    send(FUNC_EDGE, 1'b1, 1'b0);
    send(FUNC_TICK, 1'b1, 1'b1);
    send(FUNC_TICK, 1'b1, 1'b1);
    send(FUNC_TICK, 1'b0, 1'b0);
    send(FUNC_TICK, 1'b0, 1'b0);
    send(FUNC_READ, 1'b1, 1'b1);
    drain_pipeline();
  endtask

  // A bottom short press is never read, so the later top long press replaces it.
  task automatic test_overwritten_code();
    send(FUNC_EDGE, 1'b0, 1'b0);
    send(FUNC_TICK, 1'b0, 1'b1);
    send(FUNC_TICK, 1'b0, 1'b1);
    send(FUNC_TICK, 1'b0, 1'b0);
    send(FUNC_TICK, 1'b0, 1'b0);
    send(FUNC_EDGE, 1'b0, 1'b0);
    send(FUNC_TICK, 1'b1, 1'b0);
    send(FUNC_TICK, 1'b1, 1'b0);
    send(FUNC_TICK, 1'b1, 1'b1);
    send(FUNC_TICK, 1'b1, 1'b0);
    send(FUNC_TICK, 1'b0, 1'b1);
    send(FUNC_TICK, 1'b0, 1'b0);
    send(FUNC_READ, 1'b0, 1'b0);
    send(FUNC_READ, 1'b0, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_no_press();
    send(FUNC_EDGE, 1'b1, 1'b1);
    send(FUNC_TICK, 1'b0, 1'b0);
    send(FUNC_TICK, 1'b0, 1'b0);
    drain_pipeline();
  endtask

  task automatic test_fast_timing_no_idling();
    configure(8'd1, 8'd25, 8'd26, 8'd201);
    run_random_phase(0, 0, 100);
  endtask

  task automatic test_reset_timing_sender_idle();
    configure(8'(SAMPLE_TICK_RESET), 8'(BEEP_END_TICK_RESET), 8'(LONG_PRESS_TICK_RESET),
              8'(REARM_TICK_RESET));
    run_random_phase(75, 0, 50);
  endtask

  task automatic test_slow_timing_receiver_stall();
    configure(8'd23, 8'd123, 8'd199, 8'd255);
    run_random_phase(0, 75, 30);
  endtask

  task automatic test_random_timing_both_idle();
    configure(8'($urandom_range(1, 23)), 8'($urandom_range(25, 123)),
              8'($urandom_range(26, 199)), 8'($urandom_range(201, 255)));
    run_random_phase(15, 15, 50);
  endtask

  // Full-width values land outside the usual ranges; sample and beep-end values get masked to register width.
  task automatic test_masked_registers();
    configure(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    run_random_phase(0, 0, 30);
  endtask

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = due_results.pop_front();
        if (outcome.buzzer !== want.buzzer)
          report_mismatch($sformatf("buzzer %b, want %b", outcome.buzzer, want.buzzer));
        if (outcome.press_code !== want.press_code)
          report_mismatch($sformatf("press_code %0d, want %0d",
                                    outcome.press_code, want.press_code));
        if (outcome.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, want %b", outcome.busy_res, want.busy_res));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    request = '0;
    result_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    items_sent = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    q_cfg.sample_tick = SAMPLE_TICK_RESET;
    q_cfg.beep_end_tick = BEEP_END_TICK_RESET;
    q_cfg.long_press_tick = LONG_PRESS_TICK_RESET;
    q_cfg.rearm_tick = REARM_TICK_RESET;
    q_count = '0;
    q_running = 1'b0;
    q_latched_bottom = 1'b0;
    q_pending = CODE_NONE;
    q_buzzer = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(8'd1, 8'd25, 8'd26, 8'd201);
    test_quiet_items();
    test_short_press();
    test_overwritten_code();
    test_no_press();
    test_fast_timing_no_idling();
    test_reset_timing_sender_idle();
    test_slow_timing_receiver_stall();
    test_random_timing_both_idle();
    test_masked_registers();

    drain_pipeline();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/tbslp_pkg.sv
hdl/tbslp_cfg_regs.sv
hdl/tbslp_in_reg.sv
hdl/tbslp_core.sv
hdl/tbslp_out_reg.sv
hdl/two_button_short_long_press.sv
test/testbench.sv
